// ===== rtl/input_trigger_qualifier_macros.svh =====
// assertion macros used by the checker file
`ifndef INPUT_TRIGGER_QUALIFIER_MACROS_SVH
`define INPUT_TRIGGER_QUALIFIER_MACROS_SVH

// property checked outside reset
`define ITQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also holds while reset is applied
`define ITQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/itq_pkg.sv =====
// types and constants of the input trigger qualifier
package itq_pkg;

  localparam int MAG_W      = 12;
  localparam int DT_W       = 16;
  localparam int THR_W      = 12;
  localparam int DUR_W      = 24;
  localparam int LIMIT_W    = 16;
  localparam int ACC_W      = 32;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int STATUS_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd4;

  localparam logic [THR_W-1:0] DEF_THRESHOLD = 12'd2048;
  localparam logic [ACC_W-1:0] DEF_LONG_US   = 32'd1000000;
  localparam logic [ACC_W-1:0] DEF_TAP_US    = 32'd200000;

  typedef enum logic [2:0] {
    MODE_DOWN         = 3'd0,
    MODE_PRESSED      = 3'd1,
    MODE_RELEASED     = 3'd2,
    MODE_HOLD         = 3'd3,
    MODE_HOLD_RELEASE = 3'd4,
    MODE_TAP          = 3'd5,
    MODE_PULSE        = 3'd6,
    MODE_CHORDED      = 3'd7
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE      = 2'd0,
    ST_ONGOING   = 2'd1,
    ST_TRIGGERED = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                mode;
    logic [THR_W-1:0]     threshold;
    logic [DUR_W-1:0]     duration;
    logic                 flag;
    logic [LIMIT_W-1:0]   limit;
  } cfg_t;

endpackage

// ===== rtl/itq_ifs.sv =====
// valid/ready channel interfaces for frames and trigger results
interface itq_in_if;
  logic                      valid;
  logic                      ready;
  logic [itq_pkg::MAG_W-1:0] magnitude;
  logic [itq_pkg::DT_W-1:0]  frame_time_us;
  logic                      chord_ok;

  modport source (output valid, output magnitude, output frame_time_us, output chord_ok,
                  input ready);
  modport sink (input valid, input magnitude, input frame_time_us, input chord_ok,
                output ready);
endinterface

interface itq_out_if;
  logic                         valid;
  logic                         ready;
  logic [itq_pkg::STATUS_W-1:0] trigger_status;

  modport source (output valid, output trigger_status, input ready);
  modport sink (input valid, input trigger_status, output ready);
endinterface

// ===== rtl/input_trigger_qualifier.sv =====
// input trigger qualifier: two-stage frame pipeline
// path: a frame is registered in the input stage, its status then in the result register
// throughput: one frame per cycle while results are taken; the state update in itq_core is one pass
// a stalled result register holds while the input register still takes one frame
// synchronous reset empties both stages, clears trigger state, loads register defaults
module input_trigger_qualifier (
  input  logic                           clk,
  input  logic                           rst_n,
  itq_in_if.sink                         in_ch,
  itq_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [itq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [itq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  itq_pkg::cfg_t cfg;

  logic                      s1_valid_r, s1_valid_nxt;
  logic [itq_pkg::MAG_W-1:0] s1_mag_r;
  logic [itq_pkg::DT_W-1:0]  s1_dt_r;
  logic                      s1_chord_r;
  logic                      out_valid_r, out_valid_nxt;
  itq_pkg::status_t          out_status_r;
  itq_pkg::status_t          status;
  logic                      in_xfer;
  logic                      out_load;

  itq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  itq_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (out_load),
    .magnitude     (s1_mag_r),
    .frame_time_us (s1_dt_r),
    .chord_ok      (s1_chord_r),
    .cfg           (cfg),
    .status        (status)
  );

  assign out_load    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!s1_valid_r || out_load);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mag_r   <= in_ch.magnitude;
      s1_dt_r    <= in_ch.frame_time_us;
      s1_chord_r <= in_ch.chord_ok;
    end
    if (out_load) begin
      out_status_r <= status;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.trigger_status = out_status_r;

endmodule

// ===== rtl/itq_cfg_regs.sv =====
// configuration register file
module itq_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [itq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [itq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output itq_pkg::cfg_t                  cfg
);

  itq_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= itq_pkg::MODE_DOWN;
      cfg_r.threshold <= itq_pkg::DEF_THRESHOLD;
      cfg_r.duration  <= '0;
      cfg_r.flag      <= 1'b0;
      cfg_r.limit     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        itq_pkg::REG_MODE:      cfg_r.mode      <= itq_pkg::mode_t'(cfg_wdata[2:0]);
        itq_pkg::REG_THRESHOLD: cfg_r.threshold <= cfg_wdata[itq_pkg::THR_W-1:0];
        itq_pkg::REG_DURATION:  cfg_r.duration  <= cfg_wdata[itq_pkg::DUR_W-1:0];
        itq_pkg::REG_FLAG:      cfg_r.flag      <= cfg_wdata[0];
        itq_pkg::REG_LIMIT:     cfg_r.limit     <= cfg_wdata[itq_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/itq_core.sv =====
// trigger state registers and per-frame status logic
module itq_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [itq_pkg::MAG_W-1:0] magnitude,
  input  logic [itq_pkg::DT_W-1:0]  frame_time_us,
  input  logic                      chord_ok,
  input  itq_pkg::cfg_t             cfg,
  output itq_pkg::status_t          status
);

  localparam int AW = itq_pkg::ACC_W;

  logic                        was_act_r;
  logic [AW-1:0]               held_r, held_nxt;
  logic                        fired_r, fired_nxt;
  logic [AW-1:0]               accum_r, accum_nxt;
  logic [itq_pkg::LIMIT_W-1:0] count_r, count_nxt;

  logic [itq_pkg::THR_W-1:0] thr;
  logic                      act;
  logic [AW-1:0]             dur_ext;
  logic [AW-1:0]             need_long;
  logic [AW-1:0]             need_tap;
  logic [AW:0]               held_sum;
  logic [AW-1:0]             held_add;
  logic [AW:0]               accum_sum;
  logic [AW-1:0]             accum_add;
  logic                      pulse_fire;

  assign thr = (cfg.threshold == '0) ? itq_pkg::DEF_THRESHOLD : cfg.threshold;
  assign act = (magnitude >= thr);

  assign dur_ext   = {{(AW-itq_pkg::DUR_W){1'b0}}, cfg.duration};
  assign need_long = (cfg.duration == '0) ? itq_pkg::DEF_LONG_US : dur_ext;
  assign need_tap  = (cfg.duration == '0) ? itq_pkg::DEF_TAP_US : dur_ext;

  // saturating accumulators
  assign held_sum  = {1'b0, held_r} + {{(AW+1-itq_pkg::DT_W){1'b0}}, frame_time_us};
  assign held_add  = held_sum[AW] ? '1 : held_sum[AW-1:0];
  assign accum_sum = {1'b0, accum_r} + {{(AW+1-itq_pkg::DT_W){1'b0}}, frame_time_us};
  assign accum_add = accum_sum[AW] ? '1 : accum_sum[AW-1:0];

  always_comb begin
    held_nxt   = held_r;
    fired_nxt  = fired_r;
    accum_nxt  = accum_r;
    count_nxt  = count_r;
    pulse_fire = 1'b0;
    status     = itq_pkg::ST_NONE;
    unique case (cfg.mode)
      itq_pkg::MODE_DOWN: begin
        status = act ? itq_pkg::ST_TRIGGERED : itq_pkg::ST_NONE;
      end
      itq_pkg::MODE_PRESSED: begin
        status = (act && !was_act_r) ? itq_pkg::ST_TRIGGERED : itq_pkg::ST_NONE;
      end
      itq_pkg::MODE_RELEASED: begin
        if (act) begin
          status = itq_pkg::ST_ONGOING;
        end else begin
          status = was_act_r ? itq_pkg::ST_TRIGGERED : itq_pkg::ST_NONE;
        end
      end
      itq_pkg::MODE_HOLD: begin
        if (!act) begin
          held_nxt  = '0;
          fired_nxt = 1'b0;
        end else begin
          held_nxt = held_add;
          if (held_add >= need_long) begin
            if (cfg.flag && fired_r) begin
              status = itq_pkg::ST_ONGOING;
            end else begin
              fired_nxt = 1'b1;
              status    = itq_pkg::ST_TRIGGERED;
            end
          end else begin
            status = itq_pkg::ST_ONGOING;
          end
        end
      end
      itq_pkg::MODE_HOLD_RELEASE: begin
        if (act) begin
          held_nxt = held_add;
          status   = itq_pkg::ST_ONGOING;
        end else begin
          held_nxt = '0;
          status   = (was_act_r && (held_r >= need_long)) ? itq_pkg::ST_TRIGGERED
                                                         : itq_pkg::ST_NONE;
        end
      end
      itq_pkg::MODE_TAP: begin
        if (act) begin
          held_nxt = held_add;
          status   = itq_pkg::ST_ONGOING;
        end else begin
          held_nxt = '0;
          status   = (was_act_r && (held_r <= need_tap)) ? itq_pkg::ST_TRIGGERED
                                                        : itq_pkg::ST_NONE;
        end
      end
      itq_pkg::MODE_PULSE: begin
        if (!act) begin
          accum_nxt = '0;
          count_nxt = '0;
        end else begin
          if (!was_act_r) begin
            accum_nxt  = '0;
            pulse_fire = cfg.flag;
          end else begin
            accum_nxt = accum_add;
            // one interval per frame even when several are owed
            if (accum_add >= need_long) begin
              accum_nxt  = accum_add - need_long;
              pulse_fire = 1'b1;
            end
          end
          if (pulse_fire) begin
            if ((cfg.limit != '0) && (count_r >= cfg.limit)) begin
              status = itq_pkg::ST_ONGOING;
            end else begin
              if (count_r != '1) begin
                count_nxt = count_r + 1'b1;
              end
              status = itq_pkg::ST_TRIGGERED;
            end
          end else begin
            status = itq_pkg::ST_ONGOING;
          end
        end
      end
      itq_pkg::MODE_CHORDED: begin
        status = chord_ok ? itq_pkg::ST_TRIGGERED : itq_pkg::ST_NONE;
      end
      default: begin
        status = itq_pkg::ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_act_r <= 1'b0;
      held_r    <= '0;
      fired_r   <= 1'b0;
      accum_r   <= '0;
      count_r   <= '0;
    end else if (step) begin
      was_act_r <= act;
      held_r    <= held_nxt;
      fired_r   <= fired_nxt;
      accum_r   <= accum_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// ===== rtl/itq_checker.sv =====
// port-level checker for the input trigger qualifier, bound to the top level
`include "input_trigger_qualifier_macros.svh"

module itq_port_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [itq_pkg::STATUS_W-1:0] out_status
);

  `ITQ_ASSERT_RST(a_reset_empties, !rst_n |=> !out_valid, "result valid after reset")
  `ITQ_ASSERT(a_in_gives_out, in_valid && in_ready |=> ##1 out_valid, "frame produced no result")
  `ITQ_ASSERT(a_status_code, out_valid |-> out_status <= itq_pkg::ST_TRIGGERED, "bad status")
  `ITQ_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_status), "stalled")

endmodule

bind input_trigger_qualifier itq_port_checker u_itq_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.trigger_status)
);
